// ===== design/rhsi_pkg.sv =====
// Shared types, constants and the arctangent table for the RGB to HSI converter.
`timescale 1ns / 1ps
package rhsi_pkg;

  // Default hue resolution in bits.
  localparam int HUE_BITS_DEF = 12;
  // Number of rotation cells in the angle chain.
  localparam int CORDIC_STEPS = 32;
  // Number of quotient bits for saturation.
  localparam int QUOT_BITS = 13;
  // Width of the rotation vector components.
  localparam int VEC_W = 37;
  // Width of the saturation dividend and divisor.
  localparam int NUM_W = 23;
  localparam int DEN_W = 11;
  // Output field widths.
  localparam int HUE_W = 12;
  localparam int SAT_W = 13;
  localparam int INT_W = 16;
  // round(sqrt(3) * 2^24).
  localparam logic [25:0] SQRT3_Q24 = 26'd29058991;
  // ceil(2^22 / 6) for the division by six.
  localparam logic [19:0] RECIP6_Q22 = 20'd699051;

  // Data carried from cell to cell.
  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic [31:0]             z;
    logic [NUM_W-1:0]        rem;
    logic [DEN_W-1:0]        den;
    logic [QUOT_BITS-1:0]    quo;
    logic                    gray;
    logic                    zero_sum;
    logic [INT_W-1:0]        inten;
    logic                    last;
  } rhsi_stage_t;

  // Angle of atan(2^-i) in units of 2^-32 of a full turn.
  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

endpackage

// ===== design/rhsi_prep.sv =====
// Entry stage: builds the start vector, the saturation division and the intensity.
`timescale 1ns / 1ps
module rhsi_prep
  import rhsi_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        vin,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic        last_pixel,
  output logic        vout,
  output rhsi_stage_t st_o
);

  logic              valid_r;
  rhsi_stage_t       st_r;
  rhsi_stage_t       st_nxt;
  logic [9:0]        sum;
  logic [7:0]        mn;
  logic [9:0]        mn3;
  logic signed [10:0] dx;
  logic signed [8:0] dy;
  logic signed [VEC_W-1:0] x0;
  logic signed [VEC_W-1:0] y0;
  logic [18:0]       inum;
  logic [38:0]       iprod;

  // Component sum, minimum and difference terms.
  always_comb begin
    sum = 10'(red) + 10'(green) + 10'(blue);
    mn  = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    mn3 = 10'(mn) + 10'(mn) + 10'(mn);
    dx  = 11'(signed'({3'b000, red}) + signed'({3'b000, red})
          - signed'({3'b000, green}) - signed'({3'b000, blue}));
    dy  = signed'({1'b0, green}) - signed'({1'b0, blue});
    x0  = VEC_W'(dx) <<< 24;
    y0  = VEC_W'(dy) * VEC_W'(signed'({1'b0, SQRT3_Q24}));
    inum  = {sum, 9'd0} + 19'd3;
    iprod = 39'(inum) * 39'(RECIP6_Q22);
  end

  // Start vector folded into the right half plane, divider preset.
  always_comb begin
    st_nxt.x        = (dx < 0) ? -x0 : x0;
    st_nxt.y        = (dx < 0) ? -y0 : y0;
    st_nxt.z        = (dx < 0) ? 32'h80000000 : 32'h0;
    st_nxt.rem      = {(sum - mn3), 13'd0} + NUM_W'(sum);
    st_nxt.den      = {sum, 1'b0};
    st_nxt.quo      = '0;
    st_nxt.gray     = (mn3 == sum);
    st_nxt.zero_sum = (sum == 10'd0);
    st_nxt.inten    = iprod[22 +: INT_W];
    st_nxt.last     = last_pixel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign vout = valid_r;
  assign st_o = st_r;

endmodule

// ===== design/rhsi_cell.sv =====
// One cell of the chain: a rotation step and, in the first cells, one quotient bit.
`timescale 1ns / 1ps
module rhsi_cell
  import rhsi_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        vin,
  input  rhsi_stage_t st_i,
  output logic        vout,
  output rhsi_stage_t st_o
);

  logic              valid_r;
  rhsi_stage_t       st_r;
  rhsi_stage_t       st_nxt;
  logic signed [VEC_W-1:0] xs;
  logic signed [VEC_W-1:0] ys;

  // Rotation toward the x axis, accumulating the angle.
  always_comb begin
    st_nxt = st_i;
    xs = st_i.x >>> IDX;
    ys = st_i.y >>> IDX;
    if (st_i.y < 0) begin
      st_nxt.x = st_i.x - ys;
      st_nxt.y = st_i.y + xs;
      st_nxt.z = st_i.z - ATAN_TURNS[IDX];
    end else begin
      st_nxt.x = st_i.x + ys;
      st_nxt.y = st_i.y - xs;
      st_nxt.z = st_i.z + ATAN_TURNS[IDX];
    end
    // Restoring division step for quotient bit QUOT_BITS-1-IDX.
    if (IDX < QUOT_BITS) begin
      if ({1'b0, st_i.rem} >= ((NUM_W+1)'(st_i.den) << (QUOT_BITS - 1 - IDX))) begin
        st_nxt.rem = st_i.rem - NUM_W'((NUM_W+1)'(st_i.den) << (QUOT_BITS - 1 - IDX));
        st_nxt.quo = {st_i.quo[QUOT_BITS-2:0], 1'b1};
      end else begin
        st_nxt.quo = {st_i.quo[QUOT_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign vout = valid_r;
  assign st_o = st_r;

endmodule

// ===== design/rgb_to_hsi_pixel.sv =====
// Top level of the RGB to HSI pixel converter.
// Use: drive one pixel per request on the in_ channel (in_valid, in_stall) and
// take one hue, saturation, intensity result per request on the out_ channel.
// Every accepted pixel gives exactly one result, in order.
// From acceptance to out_valid a pixel passes one entry stage and a
// chain of 32 registered rotation cells, which also resolve the 13-bit
// saturation quotient in their first 13 cells.
// Throughput is one pixel per clock while the receiver takes results.
// The last cell register is the output register. When the receiver stalls a
// valid result, the whole chain holds and in_stall rises in the same cycle;
// the result stays unchanged until taken.
// A synchronous low rst_n empties the chain; no pixel is in flight afterward.
// Hue is in units of 2*pi/2^HUE_BITS, shown in a 12-bit field.
`timescale 1ns / 1ps
module rgb_to_hsi_pixel
  import rhsi_pkg::*;
#(
  parameter int HUE_BITS = HUE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_red,
  input  logic [7:0]        in_green,
  input  logic [7:0]        in_blue,
  input  logic              in_last_pixel,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [HUE_W-1:0]  out_hue_angle,
  output logic [SAT_W-1:0]  out_saturation,
  output logic [INT_W-1:0]  out_intensity,
  output logic              out_last_out
);

  logic        en;
  logic        vld   [CORDIC_STEPS+1];
  rhsi_stage_t stage [CORDIC_STEPS+1];
  logic [31:0] zr;
  logic [HUE_BITS-1:0] hue_full;
  logic [15:0] hue_ext;

  // The chain moves unless a finished result is being held.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  rhsi_prep u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .vin        (in_valid),
    .red        (in_red),
    .green      (in_green),
    .blue       (in_blue),
    .last_pixel (in_last_pixel),
    .vout       (vld[0]),
    .st_o       (stage[0])
  );

  // Row of rotation cells.
  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    rhsi_cell #(.IDX(g)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vin   (vld[g]),
      .st_i  (stage[g]),
      .vout  (vld[g+1]),
      .st_o  (stage[g+1])
    );
  end

  // Round the angle to the hue resolution and fill the result fields.
  always_comb begin
    zr       = stage[CORDIC_STEPS].z + (32'd1 << (31 - HUE_BITS));
    hue_full = zr[31 -: HUE_BITS];
    hue_ext  = 16'(hue_full);
  end

  assign out_valid      = vld[CORDIC_STEPS];
  assign out_hue_angle  = stage[CORDIC_STEPS].gray ? '0 : hue_ext[HUE_W-1:0];
  assign out_saturation = stage[CORDIC_STEPS].zero_sum ? '0 : stage[CORDIC_STEPS].quo;
  assign out_intensity  = stage[CORDIC_STEPS].inten;
  assign out_last_out   = stage[CORDIC_STEPS].last;

endmodule

// ===== design/rhsi_checker.sv =====
// Port-level checks for the RGB to HSI converter and their binding.
`timescale 1ns / 1ps
module rhsi_checker
  import rhsi_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [HUE_W-1:0] out_hue_angle,
  input logic [SAT_W-1:0] out_saturation,
  input logic [INT_W-1:0] out_intensity
);

  // A held result stays valid.
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A held result keeps its payload.
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_hue_angle) && $stable(out_saturation)
      && $stable(out_intensity))
    else $error("result changed while stalled");

  // The input side is only blocked by a held result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  // Saturation never exceeds one, and a black pixel has no hue or saturation.
  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_saturation <= SAT_W'(4096)
      && (out_intensity != '0 || (out_saturation == '0 && out_hue_angle == '0)))
    else $error("saturation out of range");

endmodule

bind rgb_to_hsi_pixel rhsi_checker u_rhsi_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_hue_angle  (out_hue_angle),
  .out_saturation (out_saturation),
  .out_intensity  (out_intensity)
);

// ===== tb/rgb_to_hsi_pixel_tb.sv =====
// Testbench for the RGB to HSI pixel converter: random and directed pixels, checked in order.
`timescale 1ns / 1ps
module rgb_to_hsi_pixel_tb;
  import rhsi_pkg::*;

  typedef struct {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] sat;
    logic [INT_W-1:0] inten;
    logic             last;
  } hsi_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [7:0]        in_red;
  logic [7:0]        in_green;
  logic [7:0]        in_blue;
  logic              in_last_pixel;
  logic              out_valid;
  logic              out_stall;
  logic [HUE_W-1:0]  out_hue_angle;
  logic [SAT_W-1:0]  out_saturation;
  logic [INT_W-1:0]  out_intensity;
  logic              out_last_out;

  hsi_t pending_hsi[$];
  int   error_count;
  bit   sender_gaps;
  bit   receiver_gaps;
  int   hold_cycles;

  rgb_to_hsi_pixel dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
    .in_last_pixel(in_last_pixel),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_hue_angle(out_hue_angle), .out_saturation(out_saturation),
    .out_intensity(out_intensity), .out_last_out(out_last_out)
  );

  // Clock with a 2 ns period.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Floor shift of a signed value, written out to avoid any tool quirks.
  function automatic longint floor_shr(longint v, int k);
    if (v >= 0) return v >>> k;
    return -((-(v + 1)) >>> k) - 1;
  endfunction

  // Hue angle by vectoring rotation over 32 cells.
  function automatic logic [HUE_W-1:0] hue_turns(int r, int g, int b);
    longint    x, y, xs, ys;
    logic [31:0] z;
    x = longint'(2 * r - g - b) * 64'sd16777216;
    y = longint'(g - b) * longint'(SQRT3_Q24);
    z = 32'd0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h80000000;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      if (y < 0) begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_TURNS[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_TURNS[i];
      end
    end
    z = z + (32'd1 << (31 - HUE_BITS_DEF));
    return HUE_W'(z >> (32 - HUE_BITS_DEF));
  endfunction

  // Full conversion of one pixel.
  function automatic hsi_t convert_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                         logic last);
    hsi_t res;
    int unsigned sum, mn;
    sum = r + g + b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    res.sat = '0;
    res.hue = '0;
    if (sum != 0) res.sat = SAT_W'((8192 * (sum - 3 * mn) + sum) / (2 * sum));
    if (3 * mn != sum) res.hue = hue_turns(r, g, b);
    res.inten = INT_W'((512 * sum + 3) / 6);
    res.last = last;
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    error_count++;
  endtask

  // Send one pixel request and record its expected result on acceptance.
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic last);
    if (sender_gaps && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    in_last_pixel <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_hsi.push_back(convert_pixel(r, g, b, last));
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
  endtask

  // Result checker.
  always @(posedge clk) begin
    hsi_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_hsi.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = pending_hsi.pop_front();
        if (out_hue_angle !== want.hue) report_mismatch("hue", out_hue_angle, want.hue);
        if (out_saturation !== want.sat)
          report_mismatch("saturation", out_saturation, want.sat);
        if (out_intensity !== want.inten)
          report_mismatch("intensity", out_intensity, want.inten);
        if (out_last_out !== want.last) report_mismatch("last", out_last_out, want.last);
      end
    end
  end

  // Receiver stall: a long hold when requested, otherwise random bursts.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (receiver_gaps && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      hold_cycles <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic test_extremes();
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd128, 8'd128, 8'd128, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b1);
    send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd255, 1'b1);
    send_pixel(8'd1, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd1, 1'b0);
    send_pixel(8'd0, 8'd1, 8'd0, 1'b0);
    send_pixel(8'd254, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd254, 8'd254, 1'b1);
    send_pixel(8'd100, 8'd50, 8'd51, 1'b0);
    send_pixel(8'd100, 8'd51, 8'd50, 1'b0);
    send_pixel(8'd0, 8'd128, 8'd127, 1'b0);
    send_pixel(8'd0, 8'd127, 8'd128, 1'b1);
  endtask

  task automatic test_random(int count);
    logic [7:0] base;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 3) == 0) begin
        // Near-gray pixels exercise small differences.
        base = $urandom_range(0, 255);
        send_pixel(base ^ 8'($urandom_range(0, 3)), base ^ 8'($urandom_range(0, 3)),
                   base ^ 8'($urandom_range(0, 3)), 1'($urandom));
      end else begin
        send_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 255), 1'($urandom));
      end
    end
  endtask

  // The receiver holds off while the sender keeps offering pixels.
  // The hold count is loaded between edges so the stall process sees it cleanly.
  task automatic test_backpressure();
    go_idle();
    @(negedge clk);
    hold_cycles = 120;
    @(posedge clk);
    test_random(80);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_red = '0;
    in_green = '0;
    in_blue = '0;
    in_last_pixel = 1'b0;
    out_stall = 1'b0;
    error_count = 0;
    hold_cycles = 0;
    sender_gaps = 1'b1;
    receiver_gaps = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_backpressure();
    test_random(1500);
    sender_gaps = 1'b0;
    receiver_gaps = 1'b0;
    test_random(400);
    go_idle();
    while (pending_hsi.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #200000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
